// ----- design/ple_pkg.sv -----
// shared types, codes and defaults for the positional list engine
`default_nettype none

package ple_pkg;

  // field widths of the request and response items
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned POSITION_W = 5;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LENGTH_W   = 5;

  // parameter defaults
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_FRONT    = 3'd0,
    ACT_ADD_REAR     = 3'd1,
    ACT_INSERT_AT    = 3'd2,
    ACT_REMOVE_FRONT = 3'd3,
    ACT_REMOVE_REAR  = 3'd4,
    ACT_REMOVE_AT    = 3'd5
  } ple_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_UNDERFLOW = 2'd1,
    STS_RANGE     = 2'd2,
    STS_FULL      = 2'd3
  } ple_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP_RD,
    ST_UP_WR,
    ST_PUT,
    ST_RM_RD,
    ST_RM_CAP,
    ST_DN_RD,
    ST_DN_WR,
    ST_FINISH
  } ple_state_e;

  typedef enum logic [2:0] {
    KOP_HOLD,
    KOP_LOAD_INS,
    KOP_LOAD_RM,
    KOP_DEC,
    KOP_INC
  } ple_kop_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_K_MINUS,
    RD_IDX,
    RD_K_PLUS
  } ple_rd_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_PUT
  } ple_wr_e;

  // controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     load_item;
    ple_kop_e k_op;
    ple_rd_e  rd_sel;
    ple_wr_e  wr_sel;
    logic     cap_removed;
    logic     finish;
  } ple_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic ins_ok;
    logic rm_ok;
    logic ins_no_shift;
    logic up_last;
    logic dn_first_more;
    logic dn_more;
    logic out_free;
  } ple_stat_t;

endpackage

`default_nettype wire

// ----- design/ple_req_if.sv -----
// request channel: action, position and value with valid/ready
`default_nettype none

interface ple_req_if;
  import ple_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [POSITION_W-1:0] position;
  logic [VALUE_W-1:0]    value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

`default_nettype wire

// ----- design/ple_rsp_if.sv -----
// response channel: status, removed value and length with valid/ready
`default_nettype none

interface ple_rsp_if;
  import ple_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  removed_value;
  logic [LENGTH_W-1:0] length;

  modport source (output valid, status, removed_value, length, input ready);
  modport sink   (input valid, status, removed_value, length, output ready);
endinterface

`default_nettype wire

// ----- design/positional_list_engine_top.sv -----
// top level of the positional list engine: controller plus datapath
`default_nettype none

// Bounded ordered list of up to CAPACITY values addressed by 1-based
// positions. One request per transfer: add front, add rear, insert at a
// position, remove front, remove rear or remove at a position; each gives
// one response with status, removed value (zero unless a removal succeeded)
// and the length afterwards (low five bits of the count). Elements live in
// a single-port-read, single-port-write memory and are moved one at a time,
// each moved element read and then written. A rejected or ignored request
// goes straight to the response register; an insert first shifts the m
// elements behind its position up and then writes the new value; a removal
// reads and captures the removed value and then shifts the m elements
// behind it down, where m is at most CAPACITY - 1. A new request is taken
// once the previous one has been loaded into the response register, even
// while that response still waits for its transfer; a finished request
// holds until the response register is free.

module positional_list_engine_top #(
  parameter int unsigned CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);
  import ple_pkg::*;

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ple_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

// ----- design/ple_ctrl.sv -----
// sequencing state machine for the positional list engine
`default_nettype none

module ple_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ple_pkg::ple_stat_t  stat_i,
  output ple_pkg::ple_cmd_t        cmd_o
);
  import ple_pkg::*;

  ple_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat_i.ins_ok) begin
          state_d = stat_i.ins_no_shift ? ST_PUT : ST_UP_RD;
        end else if (stat_i.rm_ok) begin
          state_d = ST_RM_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_UP_RD:  state_d = ST_UP_WR;
      ST_UP_WR:  state_d = stat_i.up_last ? ST_PUT : ST_UP_RD;
      ST_PUT:    state_d = ST_FINISH;
      ST_RM_RD:  state_d = ST_RM_CAP;
      ST_RM_CAP: state_d = stat_i.dn_first_more ? ST_DN_RD : ST_FINISH;
      ST_DN_RD:  state_d = ST_DN_WR;
      ST_DN_WR:  state_d = stat_i.dn_more ? ST_DN_RD : ST_FINISH;
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{
      in_ready:    1'b0,
      load_item:   1'b0,
      k_op:        KOP_HOLD,
      rd_sel:      RD_NONE,
      wr_sel:      WR_NONE,
      cap_removed: 1'b0,
      finish:      1'b0
    };
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.load_item = stat_i.in_valid;
      end
      ST_DECODE: begin
        if (stat_i.ins_ok) cmd_o.k_op = KOP_LOAD_INS;
      end
      ST_UP_RD: cmd_o.rd_sel = RD_K_MINUS;
      ST_UP_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.k_op   = KOP_DEC;
      end
      ST_PUT: cmd_o.wr_sel = WR_PUT;
      ST_RM_RD: begin
        cmd_o.rd_sel = RD_IDX;
        cmd_o.k_op   = KOP_LOAD_RM;
      end
      ST_RM_CAP: cmd_o.cap_removed = 1'b1;
      ST_DN_RD:  cmd_o.rd_sel = RD_K_PLUS;
      ST_DN_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.k_op   = KOP_INC;
      end
      ST_FINISH: cmd_o.finish = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ple_datapath.sv -----
// element memory, count, decode checks and response register
`default_nettype none

module ple_datapath #(
  parameter int unsigned CAPACITY   = ple_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ple_pkg::ple_cmd_t  cmd_i,
  output ple_pkg::ple_stat_t      stat_o,
  ple_req_if.sink                 req_i,
  ple_rsp_if.source               rsp_o
);
  import ple_pkg::*;

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
  localparam int unsigned VXW  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int unsigned LXW  = (CW > LENGTH_W) ? CW : LENGTH_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [ACTION_W-1:0]   action_q;
  logic [POSITION_W-1:0] pos_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         k_q, k_d;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] rem_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_W-1:0]    out_removed_q;
  logic [LENGTH_W-1:0]   out_length_q;

  logic [VXW-1:0]        value_ext;
  logic [VXW-1:0]        rem_ext;
  logic [LXW-1:0]        len_ext;
  logic [CMPW-1:0]       pos_ext, cnt_ext, pos_m1, k_ext;
  logic [CW-1:0]         cnt_m1;
  logic [IW-1:0]         idx, k_m1, k_p1;
  logic                  full, empty, pos_zero;
  logic                  ins_ok, rm_ok;
  ple_status_e           sts;

  logic                  rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  out_free;

  assign value_ext = VXW'(req_i.value);

  assign pos_ext  = CMPW'(pos_q);
  assign cnt_ext  = CMPW'(count_q);
  assign pos_m1   = pos_ext - CMPW'(1);
  assign cnt_m1   = count_q - CW'(1);
  assign k_ext    = CMPW'(k_q);
  assign k_m1     = k_q - IW'(1);
  assign k_p1     = k_q + IW'(1);
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign pos_zero = (pos_q == '0);

  // check the latched item against the current count
  always_comb begin
    sts    = STS_OK;
    ins_ok = 1'b0;
    rm_ok  = 1'b0;
    idx    = '0;
    case (action_q)
      ACT_ADD_FRONT: begin
        if (full) sts = STS_FULL;
        else ins_ok = 1'b1;
      end
      ACT_ADD_REAR: begin
        idx = count_q[IW-1:0];
        if (full) sts = STS_FULL;
        else ins_ok = 1'b1;
      end
      ACT_INSERT_AT: begin
        idx = pos_m1[IW-1:0];
        if (pos_zero || (pos_ext > cnt_ext + CMPW'(1))) sts = STS_RANGE;
        else if (full) sts = STS_FULL;
        else ins_ok = 1'b1;
      end
      ACT_REMOVE_FRONT: begin
        if (empty) sts = STS_UNDERFLOW;
        else rm_ok = 1'b1;
      end
      ACT_REMOVE_REAR: begin
        idx = cnt_m1[IW-1:0];
        if (empty) sts = STS_UNDERFLOW;
        else rm_ok = 1'b1;
      end
      ACT_REMOVE_AT: begin
        idx = pos_m1[IW-1:0];
        if (pos_zero || (pos_ext > cnt_ext)) sts = STS_RANGE;
        else rm_ok = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    stat_o.in_valid      = req_i.valid;
    stat_o.ins_ok        = ins_ok;
    stat_o.rm_ok         = rm_ok;
    stat_o.ins_no_shift  = (cnt_ext == CMPW'(idx));
    stat_o.up_last       = (k_m1 == idx);
    stat_o.dn_first_more = (k_ext + CMPW'(1) < cnt_ext);
    stat_o.dn_more       = (k_ext + CMPW'(2) < cnt_ext);
    stat_o.out_free      = out_free;
  end

  // latch the item on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= req_i.action;
      pos_q    <= req_i.position;
      value_q  <= value_ext[DATA_WIDTH-1:0];
    end
  end

  // shift pointer
  always_comb begin
    k_d = k_q;
    case (cmd_i.k_op)
      KOP_LOAD_INS: k_d = count_q[IW-1:0];
      KOP_LOAD_RM:  k_d = idx;
      KOP_DEC:      k_d = k_m1;
      KOP_INC:      k_d = k_p1;
      default:      k_d = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
  end

  // single read, single write element memory
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = idx;
    case (cmd_i.rd_sel)
      RD_K_MINUS: rd_addr = k_m1;
      RD_IDX:     rd_addr = idx;
      RD_K_PLUS:  rd_addr = k_p1;
      default:    rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = k_q;
    wr_data = rdata_q;
    case (cmd_i.wr_sel)
      WR_SHIFT: begin
        wr_addr = k_q;
        wr_data = rdata_q;
      end
      WR_PUT: begin
        wr_addr = idx;
        wr_data = value_q;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_removed) rem_q <= rdata_q;
  end

  assign rem_ext = VXW'(rem_q);

  always_comb begin
    count_d = count_q;
    if (ins_ok) count_d = count_q + CW'(1);
    else if (rm_ok) count_d = count_q - CW'(1);
  end

  assign len_ext = LXW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q  <= sts;
      out_removed_q <= rm_ok ? rem_ext[VALUE_W-1:0] : '0;
      out_length_q  <= len_ext[LENGTH_W-1:0];
    end
  end

  assign req_i.ready         = cmd_i.in_ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.length        = out_length_q;

endmodule

`default_nettype wire

// ----- sim/ple_list_checker.sv -----
// checker: mirrors the list contents, predicts each response and compares it
`default_nettype none

module ple_list_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ple_req_if                req_i,
  ple_rsp_if                rsp_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  import ple_pkg::*;

  localparam int unsigned CAPACITY = DEF_CAPACITY;

  typedef struct packed {
    ple_status_e         status;
    logic [VALUE_W-1:0]  removed_value;
    logic [LENGTH_W-1:0] length;
  } list_rsp_t;

  logic [VALUE_W-1:0] shadow_list[$];
  list_rsp_t          awaited_rsp_q[$];
  list_rsp_t          got;
  list_rsp_t          want;
  int unsigned        fail_count;

  // one list step on the shadow copy, returns the response it gives
  function automatic list_rsp_t apply_list_step(input logic [ACTION_W-1:0]   act,
                                                input logic [POSITION_W-1:0] pos,
                                                input logic [VALUE_W-1:0]    val);
    list_rsp_t   r;
    int unsigned cnt;
    cnt = shadow_list.size();
    r.status        = STS_OK;
    r.removed_value = '0;
    case (act)
      ACT_ADD_FRONT, ACT_ADD_REAR: begin
        if (cnt >= CAPACITY) r.status = STS_FULL;
        else if (act == ACT_ADD_FRONT) shadow_list.push_front(val);
        else shadow_list.push_back(val);
      end
      ACT_INSERT_AT: begin
        // position is checked before fullness
        if (pos == 0 || pos > cnt + 1) r.status = STS_RANGE;
        else if (cnt >= CAPACITY) r.status = STS_FULL;
        else shadow_list.insert(pos - 1, val);
      end
      ACT_REMOVE_FRONT: begin
        if (cnt == 0) r.status = STS_UNDERFLOW;
        else r.removed_value = shadow_list.pop_front();
      end
      ACT_REMOVE_REAR: begin
        if (cnt == 0) r.status = STS_UNDERFLOW;
        else r.removed_value = shadow_list.pop_back();
      end
      ACT_REMOVE_AT: begin
        if (pos == 0 || pos > cnt) r.status = STS_RANGE;
        else begin
          r.removed_value = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      default: ; // spare codes leave the list alone
    endcase
    r.length = LENGTH_W'(shadow_list.size());
    return r;
  endfunction

  initial begin
    fail_count   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.status        = ple_status_e'(rsp_i.status);
        got.removed_value = rsp_i.removed_value;
        got.length        = rsp_i.length;
        if (awaited_rsp_q.size() == 0) begin
          $error("response transfer with nothing expected: status %0d removed %h length %0d",
                 got.status, got.removed_value, got.length);
          fail_count++;
        end else begin
          want = awaited_rsp_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            fail_count++;
          end
          if (got.removed_value !== want.removed_value) begin
            $error("removed_value: expected %h, got %h", want.removed_value,
                   rsp_i.removed_value);
            fail_count++;
          end
          if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, rsp_i.length);
            fail_count++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        awaited_rsp_q.push_back(apply_list_step(req_i.action, req_i.position, req_i.value));
      fail_count_o <= fail_count;
      pending_o    <= awaited_rsp_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench top: clock, reset, request and response traffic, watchdog and verdict
`default_nettype none

module testbench;
  import ple_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1037;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 60;

  // action codes the block does not use
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count;
  int unsigned idle_cycles;
  bit          gaps_on;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  positional_list_engine_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ple_list_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!gaps_on || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // mostly near the front, where positions tend to be in range
  function automatic logic [POSITION_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return POSITION_W'($urandom_range(1, 4));
    if (r < 80) return POSITION_W'($urandom_range(1, 17));
    if (r < 90) return '0;
    return POSITION_W'($urandom_range(18, 31));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // grow phases favor adds, shrink phases favor removals
  function automatic logic [ACTION_W-1:0] pick_action(input bit grow);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    k = $urandom_range(2);
    if (r < 4) return ($urandom_range(1) != 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
    if (grow ? (r < 74) : (r < 30)) begin
      case (k)
        0:       return ACT_ADD_FRONT;
        1:       return ACT_ADD_REAR;
        default: return ACT_INSERT_AT;
      endcase
    end
    case (k)
      0:       return ACT_REMOVE_FRONT;
      1:       return ACT_REMOVE_REAR;
      default: return ACT_REMOVE_AT;
    endcase
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0]   act,
                              input logic [POSITION_W-1:0] pos,
                              input logic [VALUE_W-1:0]    val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk_i); while (!req_if.ready);
    sent_count++;
  endtask

  // request side
  initial begin
    int unsigned done;
    int unsigned phase_len;
    bit          grow;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.action   <= '0;
    req_if.position <= '0;
    req_if.value    <= '0;
    sent_count = 0;
    gaps_on    = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: underflow and range errors
    send_request(ACT_REMOVE_FRONT, 5'd1, 32'h0);
    send_request(ACT_REMOVE_REAR, 5'd31, 32'h0);
    send_request(ACT_REMOVE_AT, 5'd1, 32'h0);
    send_request(ACT_REMOVE_AT, 5'd0, 32'h0);
    send_request(ACT_INSERT_AT, 5'd0, 32'h1111_1111);
    send_request(ACT_INSERT_AT, 5'd2, 32'h2222_2222);
    // first elements, insert at the tail position count + 1
    send_request(ACT_INSERT_AT, 5'd1, 32'h0000_0000);
    send_request(ACT_ADD_FRONT, 5'd0, 32'hFFFF_FFFF);
    send_request(ACT_ADD_REAR, 5'd31, 32'h5A5A_5A5A);
    send_request(ACT_INSERT_AT, 5'd4, 32'hA5A5_A5A5);
    send_request(ACT_REMOVE_AT, 5'd2, 32'hFFFF_FFFF);
    send_request(ACT_SPARE_LO, 5'd1, 32'hDEAD_BEEF);
    send_request(ACT_SPARE_HI, 5'd2, 32'hFFFF_FFFF);

    done = 0;
    grow = 1'b1;
    while (done < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 100);
      gaps_on   = ($urandom_range(3) != 0);
      for (int unsigned i = 0; i < phase_len && done < RANDOM_ITEMS; i++) begin
        send_request(pick_action(grow), pick_position(), pick_value());
        done++;
      end
      grow = !grow;
    end
    req_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("** positional_list_engine_top: PASSED **");
    else
      $display("** positional_list_engine_top: FAILED **");
    $finish;
  end

  // response side: random ready stretches plus one long hold-off
  initial begin
    int unsigned r;
    bit          held;
    rsp_if.ready <= 1'b0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(99);
      if (!held && sent_count >= HOLD_AFTER) begin
        // input backs up while responses are held
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (r < 65) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (r < 95) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("** positional_list_engine_top: FAILED **");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/ple_pkg.sv
design/ple_req_if.sv
design/ple_rsp_if.sv
design/ple_ctrl.sv
design/ple_datapath.sv
design/positional_list_engine_top.sv
sim/ple_list_checker.sv
sim/testbench.sv
